// ----- sv/lsac_pkg.sv -----
package lsac_pkg;

    // Sensor bar geometry
    localparam int NUM_SENSORS  = 6;
    localparam int SENSOR_IDX_W = 3;
    localparam logic [SENSOR_IDX_W-1:0] LAST_SENSOR = 3'd5;

    // Level scaling
    localparam int LEVEL_W = 7;
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 7'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd100;
    localparam logic [LEVEL_W-1:0] DARK_LIMIT = 7'd60;
    localparam int NUM_EXTRA_W = 7;    // 100 * diff needs seven more bits than diff
    localparam logic [2:0] QUO_TOP_STEP = 3'd6;

    // Calibration words: black in the upper sample field, white in the lower
    localparam int CAL_W     = 20;
    localparam int CAL_EXT_W = 32;
    localparam int LIMIT_W   = 7;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_ONE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_TWO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_THREE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_FOUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_FIVE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SIX     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_WHITE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_BLACK = 3'd7;

    localparam logic [LIMIT_W-1:0] CROSS_WHITE_RESET = 7'd25;
    localparam logic [LIMIT_W-1:0] CROSS_BLACK_RESET = 7'd75;

    // Position: weighted sum, then divide by 18 via reciprocal 3641 / 2^16
    localparam int SUM_W       = 12;
    localparam int MAG_W       = 10;
    localparam int PROD_W      = 22;
    localparam int RECIP_SHIFT = 16;
    localparam int POS_W       = 7;
    localparam logic [PROD_W-1:0] RECIP_18 = 22'd3641;

    // Result word layout
    localparam int OUT_TDATA_W = 56;
    localparam int POS_LSB     = NUM_SENSORS * LEVEL_W;
    localparam int IPULSE_BIT  = POS_LSB + POS_W;
    localparam int CPULSE_BIT  = IPULSE_BIT + 1;

    typedef struct packed {
        logic capture;
        logic setup;
        logic div_step;
        logic advance;
        logic sum;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic div_last;
        logic sensor_last;
        logic out_free;
    } status_t;

    function automatic logic [CAL_W-1:0] cal_reset(input logic [SENSOR_IDX_W-1:0] idx);
        logic [CAL_W-1:0] v;
        case (idx)
            3'd0:    v = 20'd963210;
            3'd1:    v = 20'd949768;
            3'd2:    v = 20'd934246;
            3'd3:    v = 20'd934174;
            3'd4:    v = 20'd941464;
            3'd5:    v = 20'd645490;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/lsac_ctrl.sv -----
module lsac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lsac_pkg::status_t status,
    output lsac_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_SUM    = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Sequence one item: six sensors in turn, then position and detectors
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup = 1'b1;
                if (status.special) begin
                    cmd.advance = 1'b1;
                    state_next  = status.sensor_last ? ST_SUM : ST_SETUP;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    cmd.advance = 1'b1;
                    state_next  = status.sensor_last ? ST_SUM : ST_SETUP;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/lsac_datapath.sv -----
module lsac_datapath #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [lsac_pkg::NUM_SENSORS*SAMPLE_BITS-1:0] raw_in,
    input  logic                                   cfg_wr_en,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lsac_pkg::CAL_W-1:0]             cfg_wdata,
    input  lsac_pkg::cmd_t                         cmd,
    output lsac_pkg::status_t                      status,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic [lsac_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam int NUM_W = SAMPLE_BITS + lsac_pkg::NUM_EXTRA_W;
    localparam int NS    = lsac_pkg::NUM_SENSORS;
    localparam int LW    = lsac_pkg::LEVEL_W;

    // Configuration
    logic [lsac_pkg::CAL_W-1:0]   cal_reg [NS];
    logic [lsac_pkg::CAL_W-1:0]   cal_next [NS];
    logic [lsac_pkg::LIMIT_W-1:0] white_lim_reg, white_lim_next;
    logic [lsac_pkg::LIMIT_W-1:0] black_lim_reg, black_lim_next;

    // Item payload and divider
    logic [SAMPLE_BITS-1:0]           raw_reg [NS];
    logic [SAMPLE_BITS-1:0]           raw_next [NS];
    logic [LW-1:0]                    lvl_reg [NS];
    logic [LW-1:0]                    lvl_next [NS];
    logic [NUM_W-1:0]                 rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]           den_reg, den_next;
    logic [LW-1:0]                    quo_reg, quo_next;
    logic [2:0]                       step_reg, step_next;
    logic [lsac_pkg::SENSOR_IDX_W-1:0] idx_reg, idx_next;
    logic signed [lsac_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [lsac_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Detector state
    logic latched_reg, latched_next;
    logic left_dark_reg, left_dark_next;
    logic right_dark_reg, right_dark_next;
    logic left_ent_reg, left_ent_next;
    logic right_ent_reg, right_ent_next;
    logic out_valid_reg, out_valid_next;

    // Sensor setup
    logic [lsac_pkg::CAL_W-1:0]     cal_sel;
    logic [lsac_pkg::CAL_EXT_W-1:0] cal_ext;
    logic [SAMPLE_BITS-1:0]         raw_sel;
    logic [SAMPLE_BITS-1:0]         white;
    logic [SAMPLE_BITS-1:0]         black;
    logic                           bad_cal;
    logic                           saturated;
    logic [LW-1:0]                  special_lvl;
    logic [NUM_W-1:0]               diff_ext;
    logic [NUM_W-1:0]               numer;

    // Divider step
    logic [NUM_W-1:0] trial;
    logic             take;
    logic [LW-1:0]    quo_step;

    // Position and detectors
    logic signed [lsac_pkg::SUM_W-1:0] lvl_ext [NS];
    logic signed [lsac_pkg::SUM_W-1:0] sum_abs;
    logic [lsac_pkg::PROD_W-1:0]       prod;
    logic [lsac_pkg::POS_W-1:0]        pos_mag;
    logic [lsac_pkg::POS_W-1:0]        pos;
    logic                              ipulse;
    logic                              cpulse;
    logic                              left_dark_now;
    logic                              right_dark_now;
    logic                              left_ent_now;
    logic                              right_ent_now;

    // Pick out the current sensor's sample and calibration
    always_comb begin
        cal_sel     = cal_reg[idx_reg];
        raw_sel     = raw_reg[idx_reg];
        cal_ext     = lsac_pkg::CAL_EXT_W'(cal_sel);
        white       = cal_ext[SAMPLE_BITS-1:0];
        black       = cal_ext[2*SAMPLE_BITS-1:SAMPLE_BITS];
        bad_cal     = (black <= white) || (raw_sel <= white);
        saturated   = (raw_sel >= black);
        special_lvl = bad_cal ? lsac_pkg::LEVEL_ZERO : lsac_pkg::LEVEL_MAX;
        diff_ext    = NUM_W'(raw_sel - white);
        numer       = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
    end

    // One restoring step; the quotient stays below 100, so seven bits do
    always_comb begin
        trial    = NUM_W'(den_reg) << step_reg;
        take     = (rem_reg >= trial);
        quo_step = take ? (quo_reg | (LW'(1) << step_reg)) : quo_reg;
    end

    // Weighted sum and its division by 18 toward zero
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            lvl_ext[i] = lsac_pkg::SUM_W'(lvl_reg[i]);
        end
        sum_next = (lvl_ext[3] + (lvl_ext[4] <<< 1) + lvl_ext[4]
                    + (lvl_ext[5] <<< 2) + lvl_ext[5])
                 - (lvl_ext[0] + (lvl_ext[1] <<< 1) + lvl_ext[1]
                    + (lvl_ext[2] <<< 2) + lvl_ext[2]);
        if (!cmd.sum) begin
            sum_next = sum_reg;
        end
        sum_abs = sum_reg[lsac_pkg::SUM_W-1] ? -sum_reg : sum_reg;
        prod    = lsac_pkg::PROD_W'(sum_abs[lsac_pkg::MAG_W-1:0]) * lsac_pkg::RECIP_18;
        pos_mag = lsac_pkg::POS_W'(prod[lsac_pkg::PROD_W-1:lsac_pkg::RECIP_SHIFT]);
        pos     = sum_reg[lsac_pkg::SUM_W-1] ? -pos_mag : pos_mag;
    end

    // Intersection hysteresis and dark-entry tracking
    always_comb begin
        ipulse       = 1'b0;
        latched_next = latched_reg;
        if ((lvl_reg[1] < white_lim_reg) && (lvl_reg[4] < white_lim_reg)) begin
            ipulse       = !latched_reg;
            latched_next = 1'b1;
        end else if ((lvl_reg[1] > black_lim_reg) && (lvl_reg[4] > black_lim_reg)) begin
            latched_next = 1'b0;
        end
        left_dark_now  = (lvl_reg[1] < lsac_pkg::DARK_LIMIT);
        right_dark_now = (lvl_reg[4] < lsac_pkg::DARK_LIMIT);
        left_ent_now   = left_ent_reg || (left_dark_now && !left_dark_reg);
        right_ent_now  = right_ent_reg || (right_dark_now && !right_dark_reg);
        cpulse         = left_ent_now && right_ent_now;
        left_ent_next  = cpulse ? 1'b0 : left_ent_now;
        right_ent_next = cpulse ? 1'b0 : right_ent_now;
        left_dark_next  = left_dark_now;
        right_dark_next = right_dark_now;
        if (!cmd.finish) begin
            latched_next    = latched_reg;
            left_ent_next   = left_ent_reg;
            right_ent_next  = right_ent_reg;
            left_dark_next  = left_dark_reg;
            right_dark_next = right_dark_reg;
        end
    end

    // Advance the per-sensor datapath
    always_comb begin
        raw_next  = raw_reg;
        lvl_next  = lvl_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        idx_next  = idx_reg;
        if (cmd.capture) begin
            for (int i = 0; i < NS; i++) begin
                raw_next[i] = raw_in[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
            idx_next = '0;
        end
        if (cmd.setup) begin
            if (bad_cal || saturated) begin
                lvl_next[idx_reg] = special_lvl;
            end else begin
                rem_next  = numer;
                den_next  = black - white;
                quo_next  = '0;
                step_next = lsac_pkg::QUO_TOP_STEP;
            end
        end
        if (cmd.div_step) begin
            rem_next  = take ? (rem_reg - trial) : rem_reg;
            quo_next  = quo_step;
            step_next = step_reg - 3'd1;
            if (step_reg == 3'd0) begin
                lvl_next[idx_reg] = quo_step;
            end
        end
        if (cmd.advance) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    // Load the output register; drop valid once the item is taken
    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            out_data_next = '0;
            for (int i = 0; i < NS; i++) begin
                out_data_next[i*LW +: LW] = lvl_reg[i];
            end
            out_data_next[lsac_pkg::POS_LSB +: lsac_pkg::POS_W] = pos;
            out_data_next[lsac_pkg::IPULSE_BIT] = ipulse;
            out_data_next[lsac_pkg::CPULSE_BIT] = cpulse;
            out_valid_next = 1'b1;
        end
    end

    // Register writes
    always_comb begin
        cal_next       = cal_reg;
        white_lim_next = white_lim_reg;
        black_lim_next = black_lim_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                lsac_pkg::CFG_CAL_ONE:     cal_next[0] = cfg_wdata;
                lsac_pkg::CFG_CAL_TWO:     cal_next[1] = cfg_wdata;
                lsac_pkg::CFG_CAL_THREE:   cal_next[2] = cfg_wdata;
                lsac_pkg::CFG_CAL_FOUR:    cal_next[3] = cfg_wdata;
                lsac_pkg::CFG_CAL_FIVE:    cal_next[4] = cfg_wdata;
                lsac_pkg::CFG_CAL_SIX:     cal_next[5] = cfg_wdata;
                lsac_pkg::CFG_CROSS_WHITE: white_lim_next = cfg_wdata[lsac_pkg::LIMIT_W-1:0];
                lsac_pkg::CFG_CROSS_BLACK: black_lim_next = cfg_wdata[lsac_pkg::LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS; i++) begin
                cal_reg[i] <= lsac_pkg::cal_reset(lsac_pkg::SENSOR_IDX_W'(i));
            end
            white_lim_reg  <= lsac_pkg::CROSS_WHITE_RESET;
            black_lim_reg  <= lsac_pkg::CROSS_BLACK_RESET;
            latched_reg    <= 1'b0;
            left_dark_reg  <= 1'b0;
            right_dark_reg <= 1'b0;
            left_ent_reg   <= 1'b0;
            right_ent_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            step_reg       <= '0;
        end else begin
            cal_reg        <= cal_next;
            white_lim_reg  <= white_lim_next;
            black_lim_reg  <= black_lim_next;
            latched_reg    <= latched_next;
            left_dark_reg  <= left_dark_next;
            right_dark_reg <= right_dark_next;
            left_ent_reg   <= left_ent_next;
            right_ent_reg  <= right_ent_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            step_reg       <= step_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        raw_reg      <= raw_next;
        lvl_reg      <= lvl_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    assign status.special     = bad_cal || saturated;
    assign status.div_last    = (step_reg == 3'd0);
    assign status.sensor_last = (idx_reg == lsac_pkg::LAST_SENSOR);
    assign status.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- sv/line_sensor_array_conditioner.sv -----
// Each sensor takes a setup step, plus seven restoring-divider steps unless its
// level is forced to 0 or 100 by bad calibration or a saturated sample.
// Items pass one at a time through the single shared divider.
// The result waits in an output register, so the next item can start meanwhile.
// Reset (aresetn low, synchronous) restores calibration defaults, arms the
// intersection detector and clears the dark-entry flags and the output valid.
module line_sensor_array_conditioner #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // raw_one, raw_two, raw_three, raw_four, raw_five, raw_six, zero fill
    input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // level_one .. level_six, line_position, intersection_pulse,
    // crossing_pulse, zero fill
    output logic [lsac_pkg::OUT_TDATA_W-1:0]          m_tdata,
    input  logic                                      cfg_wr_en,
    input  logic [lsac_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [lsac_pkg::CAL_W-1:0]                cfg_wdata
);

    lsac_pkg::cmd_t    cmd;
    lsac_pkg::status_t status;

    lsac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lsac_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .raw_in    (s_tdata[lsac_pkg::NUM_SENSORS*SAMPLE_BITS-1:0]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- sv/lsac_checker.sv -----
module lsac_port_checks (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lsac_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // One item at a time: no second acceptance straight after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is at work");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Shown levels stay in range and the position lies within plus or minus 50
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (m_tdata[6:0] <= 7'd100) && (m_tdata[13:7] <= 7'd100)
            && (m_tdata[20:14] <= 7'd100) && (m_tdata[27:21] <= 7'd100)
            && (m_tdata[34:28] <= 7'd100) && (m_tdata[41:35] <= 7'd100)
            && ($signed(m_tdata[48:42]) >= -7'sd50)
            && ($signed(m_tdata[48:42]) <= 7'sd50))
        else $error("level or position out of range");

endmodule

bind line_sensor_array_conditioner lsac_port_checks u_lsac_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
